### rtl/core/alpha_blend_rect_fill_engine_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the alpha blend rectangle fill engine
// Concurrent checks sampled on clk_i; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ALPHA_BLEND_RECT_FILL_ENGINE_CORE_ASSERT_SVH
`define ALPHA_BLEND_RECT_FILL_ENGINE_CORE_ASSERT_SVH

`ifndef SYNTH
`define ABRF_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define ABRF_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define ABRF_ASSERT(name, prop, msg)
`define ABRF_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

### rtl/core/abrf_pkg.sv
// ----------------------------------------------------------------------------
// Alpha blend rectangle fill engine package
// Shared widths, command codes, register indexes and defaults.
// ----------------------------------------------------------------------------
package abrf_pkg;

  localparam int unsigned ChanW = 8;
  localparam int unsigned PixW = 3 * ChanW;
  localparam int unsigned CoordW = 11;
  localparam int unsigned RegW = 8;
  localparam int unsigned CfgIdxW = 1;

  localparam int unsigned DefaultMaxWidth = 128;
  localparam int unsigned DefaultMaxHeight = 128;

  localparam logic [RegW-1:0] ScreenWidthReset = 8'd128;
  localparam logic [RegW-1:0] ScreenHeightReset = 8'd128;

  localparam logic [CfgIdxW-1:0] RegScreenWidth = 1'b0;
  localparam logic [CfgIdxW-1:0] RegScreenHeight = 1'b1;

  typedef enum logic [1:0] {
    KindFill  = 2'd0,
    KindClear = 2'd1,
    KindSwap  = 2'd2,
    KindRead  = 2'd3
  } kind_e;

endpackage

### rtl/core/abrf_pix_mem.sv
// ----------------------------------------------------------------------------
// Pixel memory
// Simple dual-port synchronous RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module abrf_pix_mem #(
  parameter int unsigned AddrW = 15,
  parameter int unsigned DataW = abrf_pkg::PixW
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);

  localparam int unsigned Depth = 2 ** AddrW;

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/abrf_blend.sv
// ----------------------------------------------------------------------------
// Pixel blender
// Per-channel source-over blend: (src*a + dst*(255-a)) >> 8.
// ----------------------------------------------------------------------------
module abrf_blend (
  input  logic [abrf_pkg::PixW-1:0]  src_i,
  input  logic [abrf_pkg::PixW-1:0]  dst_i,
  input  logic [abrf_pkg::ChanW-1:0] alpha_i,
  output logic [abrf_pkg::PixW-1:0]  pix_o
);

  localparam int unsigned CW = abrf_pkg::ChanW;
  localparam int unsigned SumW = 2 * CW + 1;

  logic [CW-1:0] inv_alpha;

  assign inv_alpha = ~alpha_i;

  for (genvar c = 0; c < 3; c++) begin : g_chan
    logic [SumW-1:0] src_term;
    logic [SumW-1:0] dst_term;
    logic [SumW-1:0] sum;

    assign src_term = SumW'(src_i[c*CW +: CW] * alpha_i);
    assign dst_term = SumW'(dst_i[c*CW +: CW] * inv_alpha);
    assign sum = src_term + dst_term;
    assign pix_o[c*CW +: CW] = sum[2*CW-1:CW];
  end

endmodule

### rtl/core/alpha_blend_rect_fill_engine_core.sv
// ----------------------------------------------------------------------------
// Alpha blend rectangle fill engine core
// Double-buffered frame store with fill, clear, swap and pixel read commands.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low, and one result beat
// follows on done_o for a single cycle; the receiver cannot stall it. A fill
// or clear is a read-modify-write of every pixel through one read and one
// write port of the frame memory. Configuration writes are always ready.
module alpha_blend_rect_fill_engine_core #(
  parameter int unsigned MaxWidth = abrf_pkg::DefaultMaxWidth,
  parameter int unsigned MaxHeight = abrf_pkg::DefaultMaxHeight
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    kind_i,
  input  logic signed [10:0]            x_start_i,
  input  logic signed [10:0]            y_start_i,
  input  logic [10:0]                   rect_width_i,
  input  logic [10:0]                   rect_height_i,
  input  logic [7:0]                    red_i,
  input  logic [7:0]                    green_i,
  input  logic [7:0]                    blue_i,
  input  logic [7:0]                    alpha_i,
  output logic                          done_o,
  output logic                          status_o,
  output logic [7:0]                    read_red_o,
  output logic [7:0]                    read_green_o,
  output logic [7:0]                    read_blue_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [abrf_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [abrf_pkg::RegW-1:0]     cfg_data_i
);

  `include "alpha_blend_rect_fill_engine_core_assert.svh"

  localparam int unsigned XW = (MaxWidth > 1) ? $clog2(MaxWidth) : 1;
  localparam int unsigned YW = (MaxHeight > 1) ? $clog2(MaxHeight) : 1;
  localparam int unsigned AW = 1 + YW + XW;
  localparam int unsigned CrdW = abrf_pkg::CoordW;
  localparam int unsigned PW = abrf_pkg::PixW;
  localparam logic [CrdW-1:0] MaxW = CrdW'(MaxWidth);
  localparam logic [CrdW-1:0] MaxH = CrdW'(MaxHeight);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_FILL   = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_READ   = 3'd4;

  logic [2:0] state_q, state_d;

  abrf_pkg::kind_e         kind_q;
  logic signed [CrdW-1:0]  xs_q, ys_q;
  logic [CrdW-1:0]         rw_q, rh_q;
  logic [PW-1:0]           color_q;
  logic [7:0]              alpha_q;

  logic [abrf_pkg::RegW-1:0] scr_w_q, scr_h_q;
  logic                      sel_q;

  logic [XW-1:0] x_q, x0_q, xlast_q;
  logic [YW-1:0] y_q, ylast_q;

  logic          wr_valid_q;
  logic [AW-1:0] wr_addr_q;

  logic          done_q, status_q;
  logic          done_d, status_d;
  logic [PW-1:0] rgb_q;

  logic [CrdW-1:0] eff_w, eff_h;
  logic [CrdW:0]   x_end, y_end;
  logic            fill_ok, fill_empty, clear_empty, read_ok;
  logic [CrdW-1:0] reg_x0, reg_xlast, reg_y0, reg_ylast;
  logic            x_at_last, y_at_last;

  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [PW-1:0] mem_rdata;
  logic [PW-1:0] blend_pix;

  assign eff_w = ({3'b000, scr_w_q} > MaxW) ? MaxW : {3'b000, scr_w_q};
  assign eff_h = ({3'b000, scr_h_q} > MaxH) ? MaxH : {3'b000, scr_h_q};

  assign x_end = (CrdW + 1)'(xs_q[CrdW-2:0]) + (CrdW + 1)'(rw_q);
  assign y_end = (CrdW + 1)'(ys_q[CrdW-2:0]) + (CrdW + 1)'(rh_q);

  assign fill_ok = !xs_q[CrdW-1] && !ys_q[CrdW-1]
                   && (x_end <= {1'b0, eff_w}) && (y_end <= {1'b0, eff_h});
  assign fill_empty = (rw_q == '0) || (rh_q == '0);
  assign clear_empty = (eff_w == '0) || (eff_h == '0);
  assign read_ok = !xs_q[CrdW-1] && !ys_q[CrdW-1]
                   && ({1'b0, xs_q[CrdW-2:0]} < eff_w)
                   && ({1'b0, ys_q[CrdW-2:0]} < eff_h);

  always_comb begin
    if (kind_q == abrf_pkg::KindFill) begin
      reg_x0 = {1'b0, xs_q[CrdW-2:0]};
      reg_y0 = {1'b0, ys_q[CrdW-2:0]};
      reg_xlast = CrdW'(x_end - 1'b1);
      reg_ylast = CrdW'(y_end - 1'b1);
    end else begin
      reg_x0 = '0;
      reg_y0 = '0;
      reg_xlast = eff_w - 1'b1;
      reg_ylast = eff_h - 1'b1;
    end
  end

  assign x_at_last = (x_q == xlast_q);
  assign y_at_last = (y_q == ylast_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (kind_q)
          abrf_pkg::KindFill: begin
            state_d = (fill_ok && !fill_empty) ? S_FILL : S_IDLE;
          end
          abrf_pkg::KindClear: begin
            state_d = clear_empty ? S_IDLE : S_FILL;
          end
          abrf_pkg::KindSwap: begin
            state_d = S_IDLE;
          end
          abrf_pkg::KindRead: begin
            state_d = read_ok ? S_READ : S_IDLE;
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      S_FILL: begin
        if (x_at_last && y_at_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_IDLE;
      end
      S_READ: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    done_d = 1'b0;
    status_d = status_q;
    if (state_q == S_DECODE) begin
      status_d = 1'b0;
      unique case (kind_q)
        abrf_pkg::KindFill: begin
          status_d = !fill_ok;
          done_d = !fill_ok || fill_empty;
        end
        abrf_pkg::KindClear: begin
          done_d = clear_empty;
        end
        abrf_pkg::KindSwap: begin
          done_d = 1'b1;
        end
        abrf_pkg::KindRead: begin
          status_d = !read_ok;
          done_d = !read_ok;
        end
        default: ;
      endcase
    end
    if (state_q == S_DRAIN || state_q == S_READ) begin
      done_d = 1'b1;
      status_d = 1'b0;
    end
  end

  always_comb begin
    mem_re = 1'b0;
    mem_raddr = {sel_q, y_q, x_q};
    if (state_q == S_FILL) begin
      mem_re = 1'b1;
    end else if (state_q == S_DECODE && kind_q == abrf_pkg::KindRead && read_ok) begin
      mem_re = 1'b1;
      mem_raddr = {~sel_q, ys_q[YW-1:0], xs_q[XW-1:0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      scr_w_q <= abrf_pkg::ScreenWidthReset;
      scr_h_q <= abrf_pkg::ScreenHeightReset;
      sel_q <= 1'b0;
      wr_valid_q <= 1'b0;
      done_q <= 1'b0;
      status_q <= 1'b0;
    end else begin
      state_q <= state_d;
      wr_valid_q <= (state_q == S_FILL);
      done_q <= done_d;
      status_q <= status_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          abrf_pkg::RegScreenWidth:  scr_w_q <= cfg_data_i;
          abrf_pkg::RegScreenHeight: scr_h_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == S_DECODE && kind_q == abrf_pkg::KindSwap) begin
        sel_q <= ~sel_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start) begin
      kind_q <= abrf_pkg::kind_e'(kind_i);
      xs_q <= x_start_i;
      ys_q <= y_start_i;
      rw_q <= rect_width_i;
      rh_q <= rect_height_i;
      color_q <= {red_i, green_i, blue_i};
      alpha_q <= alpha_i;
    end
    if (state_q == S_DECODE) begin
      x_q <= reg_x0[XW-1:0];
      x0_q <= reg_x0[XW-1:0];
      y_q <= reg_y0[YW-1:0];
      xlast_q <= reg_xlast[XW-1:0];
      ylast_q <= reg_ylast[YW-1:0];
      rgb_q <= '0;
    end
    if (state_q == S_FILL) begin
      wr_addr_q <= mem_raddr;
      if (x_at_last) begin
        x_q <= x0_q;
        y_q <= y_q + 1'b1;
      end else begin
        x_q <= x_q + 1'b1;
      end
    end
    if (state_q == S_READ) begin
      rgb_q <= mem_rdata;
    end
  end

  abrf_pix_mem #(
    .AddrW (AW),
    .DataW (PW)
  ) u_pix_mem (
    .clk_i   (clk_i),
    .we_i    (wr_valid_q),
    .waddr_i (wr_addr_q),
    .wdata_i (blend_pix),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  abrf_blend u_blend (
    .src_i   (color_q),
    .dst_i   (mem_rdata),
    .alpha_i (alpha_q),
    .pix_o   (blend_pix)
  );

  assign busy = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign done_o = done_q;
  assign status_o = status_q;
  assign read_red_o = rgb_q[2*abrf_pkg::ChanW +: abrf_pkg::ChanW];
  assign read_green_o = rgb_q[abrf_pkg::ChanW +: abrf_pkg::ChanW];
  assign read_blue_o = rgb_q[0 +: abrf_pkg::ChanW];

  `ABRF_ASSERT(a_no_rmw_overlap, (wr_valid_q && mem_re) |-> (wr_addr_q != mem_raddr), "read and write hit the same pixel")
  `ABRF_ASSERT(a_idle_no_write, (!busy && !done_o) |-> !wr_valid_q, "pixel write pending while idle")
  `ABRF_ASSERT(a_fail_no_color, (done_o && status_o) |-> (rgb_q == '0), "failed command returned a color")
  `ABRF_ASSERT_ALWAYS(a_done_when_idle, done_o |-> !busy, "result beat while a command is active")

endmodule
